// File: hdl/assert_macros.svh
// assertion helpers, clocked on clk_i and disabled during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_ALWAYS(label, prop, msg)
`define ASSERT_IMPLIES(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// File: hdl/dda_pkg.sv
`timescale 1ns / 1ps

package dda_pkg;

  localparam int unsigned CoordBits = 10;
  localparam logic [7:0] AlphaByte = 8'hFF;

  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_STEP = 1'b1
  } mode_e;

  typedef struct packed {
    mode_e                mode;
    logic [CoordBits-1:0] start_x;
    logic [CoordBits-1:0] start_y;
    logic [CoordBits-1:0] end_x;
    logic [CoordBits-1:0] end_y;
    logic [7:0]           red;
    logic [7:0]           green;
    logic [7:0]           blue;
  } dda_in_t;

  typedef struct packed {
    logic [CoordBits-1:0] pixel_x;
    logic [CoordBits-1:0] pixel_y;
    logic [31:0]          pixel_colour;
    logic                 final_pixel;
  } dda_out_t;

  // position of one axis: integer part and rounding remainder
  typedef struct packed {
    logic [CoordBits-1:0] cur;
    logic [CoordBits:0]   rem;
  } axis_t;

endpackage

// File: hdl/dda_line_rasterizer.sv
// dda line rasterizer: a load item sets up a line, each step yields a pixel while it lasts
// a step item's pixel is registered into the output register if it is free or drains,
// else into the skid entry, from which it moves on when the output register drains
// throughput: one item per cycle unless stalled; one add and two compares per axis
// a two-entry output stage (register plus skid) takes one more pixel while a pixel waits,
// then stalls input until the output register drains
// reset (async, active low) leaves the block idle with no line and no pending pixel
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dda_line_rasterizer import dda_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  dda_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output dda_out_t out_data_o
);

  localparam int unsigned SumBits = CoordBits + 3;

  logic                  active_q, active_d;
  logic [CoordBits-1:0]  total_q, total_d;
  logic [CoordBits-1:0]  index_q, index_d;
  logic [CoordBits:0]    delta_x_q, delta_x_d;
  logic [CoordBits:0]    delta_y_q, delta_y_d;
  axis_t                 axis_x_q, axis_x_d;
  axis_t                 axis_y_q, axis_y_d;
  logic [31:0]           colour_q, colour_d;

  logic                  out_valid_q;
  dda_out_t              out_q;
  logic                  skid_valid_q;
  dda_out_t              skid_q;

  logic                  in_fire;
  logic                  out_fire;
  logic                  produce;
  logic                  last;
  dda_out_t              result;

  logic [CoordBits:0]    load_dx;
  logic [CoordBits:0]    load_dy;
  logic [CoordBits-1:0]  abs_dx;
  logic [CoordBits-1:0]  abs_dy;
  logic [CoordBits-1:0]  load_total;

  // rem += 2*delta, then at most one correction by 2*steps
  function automatic axis_t advance(axis_t a, logic [CoordBits:0] delta,
                                    logic [CoordBits-1:0] total);
    logic signed [SumBits-1:0] sum;
    logic signed [SumBits-1:0] span;
    axis_t                     r;
    sum  = $signed({2'b00, a.rem}) + $signed({delta[CoordBits], delta, 1'b0});
    span = $signed({2'b00, total, 1'b0});
    r    = a;
    if (sum >= span) begin
      r.rem = CoordBits'(0) + (sum[CoordBits:0] - span[CoordBits:0]);
      r.cur = a.cur + CoordBits'(1);
    end else if (sum < 0) begin
      r.rem = sum[CoordBits:0] + span[CoordBits:0];
      r.cur = a.cur - CoordBits'(1);
    end else begin
      r.rem = sum[CoordBits:0];
    end
    return r;
  endfunction

  assign in_stall_o  = skid_valid_q;
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_fire    = out_valid_q && !out_stall_i;
  assign produce     = in_fire && (in_data_i.mode == MODE_STEP) && active_q;
  assign last        = (index_q == total_q - CoordBits'(1));

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // line setup
  always_comb begin
    load_dx    = {1'b0, in_data_i.end_x} - {1'b0, in_data_i.start_x};
    load_dy    = {1'b0, in_data_i.end_y} - {1'b0, in_data_i.start_y};
    abs_dx     = load_dx[CoordBits] ? CoordBits'(-load_dx) : load_dx[CoordBits-1:0];
    abs_dy     = load_dy[CoordBits] ? CoordBits'(-load_dy) : load_dy[CoordBits-1:0];
    load_total = (abs_dx > abs_dy) ? abs_dx : abs_dy;
  end

  always_comb begin
    result.pixel_x      = axis_x_q.cur;
    result.pixel_y      = axis_y_q.cur;
    result.pixel_colour = colour_q;
    result.final_pixel  = last;
  end

  always_comb begin
    active_d  = active_q;
    total_d   = total_q;
    index_d   = index_q;
    delta_x_d = delta_x_q;
    delta_y_d = delta_y_q;
    axis_x_d  = axis_x_q;
    axis_y_d  = axis_y_q;
    colour_d  = colour_q;
    if (in_fire && (in_data_i.mode == MODE_LOAD)) begin
      delta_x_d    = load_dx;
      delta_y_d    = load_dy;
      total_d      = load_total;
      index_d      = '0;
      axis_x_d.cur = in_data_i.start_x;
      axis_y_d.cur = in_data_i.start_y;
      axis_x_d.rem = {1'b0, load_total};
      axis_y_d.rem = {1'b0, load_total};
      colour_d     = {AlphaByte, in_data_i.red, in_data_i.green, in_data_i.blue};
      active_d     = (load_total != '0);
    end else if (produce) begin
      index_d = index_q + CoordBits'(1);
      if (last) begin
        active_d = 1'b0;
      end else begin
        axis_x_d = advance(axis_x_q, delta_x_q, total_q);
        axis_y_d = advance(axis_y_q, delta_y_q, total_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      total_q   <= '0;
      index_q   <= '0;
      delta_x_q <= '0;
      delta_y_q <= '0;
      axis_x_q  <= '0;
      axis_y_q  <= '0;
      colour_q  <= '0;
    end else begin
      active_q  <= active_d;
      total_q   <= total_d;
      index_q   <= index_d;
      delta_x_q <= delta_x_d;
      delta_y_q <= delta_y_d;
      axis_x_q  <= axis_x_d;
      axis_y_q  <= axis_y_d;
      colour_q  <= colour_d;
    end
  end

  // output register with skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_fire) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= produce;
      end
    end else if (produce) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_fire) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (produce) begin
        out_q <= result;
      end
    end else if (produce) begin
      skid_q <= result;
    end
  end

  `ASSERT_IMPLIES(a_skid_needs_out, skid_valid_q, out_valid_q, "skid item without output item")
  `ASSERT_IMPLIES(a_index_in_range, active_q, index_q < total_q, "step index past line length")
  `ASSERT_IMPLIES(a_rem_x_bound, active_q, axis_x_q.rem < {total_q, 1'b0}, "x remainder out of range")
  `ASSERT_IMPLIES(a_rem_y_bound, active_q, axis_y_q.rem < {total_q, 1'b0}, "y remainder out of range")
  `ASSERT_NEXT(a_final_ends_line, produce && last, !active_q, "line still active after final pixel")

endmodule

// File: sim/pixel_checker.sv
`timescale 1ns / 1ps

module pixel_checker import dda_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_stall_i,
  input  dda_in_t  in_data_i,
  input  logic     out_valid_i,
  input  logic     out_stall_i,
  input  dda_out_t out_data_i,
  output int       failures_o,
  output int       pending_o,
  output int       compared_o
);

  localparam int ReportLimit = 10;
  localparam int QueueDepth = 64;

  dda_out_t expected_pixels [QueueDepth];
  dda_out_t oldest_pixel;
  int       wr_count;
  int       rd_count;

  logic                        drawing;
  logic [CoordBits-1:0]        pixel_count;
  logic [CoordBits-1:0]        pixel_index;
  logic signed [CoordBits:0]   run_x;
  logic signed [CoordBits:0]   run_y;
  logic [CoordBits-1:0]        pos_x;
  logic [CoordBits-1:0]        pos_y;
  logic signed [CoordBits+1:0] frac_x;
  logic signed [CoordBits+1:0] frac_y;
  logic [31:0]                 line_colour;
  int                          mismatches;
  int                          compared;

  // one step along an axis: add twice the run, then at most one carry or borrow
  function automatic logic [2*CoordBits+1:0] next_axis(
    input logic [CoordBits-1:0]        pos,
    input logic signed [CoordBits+1:0] frac,
    input logic signed [CoordBits:0]   run,
    input logic [CoordBits-1:0]        count
  );
    int span;
    int f;
    int p;
    span = 2 * int'(count);
    f = int'(frac) + 2 * int'(run);
    p = int'(pos);
    if (f >= span) begin
      f = f - span;
      p = p + 1;
    end else if (f < 0) begin
      f = f + span;
      p = p - 1;
    end
    return {p[CoordBits-1:0], f[CoordBits+1:0]};
  endfunction

  task automatic predict_pixel(input dda_in_t d);
    dda_out_t px;
    int dx;
    int dy;
    int span;
    if (d.mode == MODE_LOAD) begin
      dx = int'(d.end_x) - int'(d.start_x);
      dy = int'(d.end_y) - int'(d.start_y);
      span = (dx < 0) ? -dx : dx;
      if (((dy < 0) ? -dy : dy) > span) span = (dy < 0) ? -dy : dy;
      run_x = dx[CoordBits:0];
      run_y = dy[CoordBits:0];
      pixel_count = span[CoordBits-1:0];
      pixel_index = '0;
      pos_x = d.start_x;
      pos_y = d.start_y;
      frac_x = span[CoordBits+1:0];
      frac_y = span[CoordBits+1:0];
      line_colour = {AlphaByte, d.red, d.green, d.blue};
      drawing = (span != 0);
    end else if (drawing) begin
      px.pixel_x = pos_x;
      px.pixel_y = pos_y;
      px.pixel_colour = line_colour;
      px.final_pixel = (pixel_index == pixel_count - 1'b1);
      if (wr_count - rd_count >= QueueDepth) begin
        mismatches++;
        if (mismatches <= ReportLimit) begin
          $display("too many pixels outstanding, expected pixel dropped");
        end
      end else begin
        expected_pixels[wr_count % QueueDepth] = px;
        wr_count++;
      end
      if (px.final_pixel) begin
        drawing = 1'b0;
      end else begin
        {pos_x, frac_x} = next_axis(pos_x, frac_x, run_x, pixel_count);
        {pos_y, frac_y} = next_axis(pos_y, frac_y, run_y, pixel_count);
      end
      pixel_index = pixel_index + 1'b1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_count = 0;
      rd_count = 0;
      drawing = 1'b0;
      pixel_count = '0;
      pixel_index = '0;
      run_x = '0;
      run_y = '0;
      pos_x = '0;
      pos_y = '0;
      frac_x = '0;
      frac_y = '0;
      line_colour = '0;
      mismatches = 0;
      compared = 0;
      failures_o <= 0;
      pending_o <= 0;
      compared_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (wr_count == rd_count) begin
          mismatches++;
          if (mismatches <= ReportLimit) begin
            $display("unexpected pixel x=%0d y=%0d colour=%h final=%0b",
                     out_data_i.pixel_x, out_data_i.pixel_y,
                     out_data_i.pixel_colour, out_data_i.final_pixel);
          end
        end else begin
          oldest_pixel = expected_pixels[rd_count % QueueDepth];
          rd_count++;
          compared++;
          if (out_data_i.pixel_x !== oldest_pixel.pixel_x ||
              out_data_i.pixel_y !== oldest_pixel.pixel_y ||
              out_data_i.pixel_colour !== oldest_pixel.pixel_colour ||
              out_data_i.final_pixel !== oldest_pixel.final_pixel) begin
            mismatches++;
            if (mismatches <= ReportLimit) begin
              $display("pixel mismatch: got x=%0d y=%0d colour=%h final=%0b",
                       out_data_i.pixel_x, out_data_i.pixel_y,
                       out_data_i.pixel_colour, out_data_i.final_pixel);
              $display("            expected x=%0d y=%0d colour=%h final=%0b",
                       oldest_pixel.pixel_x, oldest_pixel.pixel_y,
                       oldest_pixel.pixel_colour, oldest_pixel.final_pixel);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) predict_pixel(in_data_i);
      failures_o <= mismatches;
      pending_o <= wr_count - rd_count;
      compared_o <= compared;
    end
  end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import dda_pkg::*;

  localparam int ItemTarget = 1650;
  localparam int HoldCycles = 200;
  localparam int CycleLimit = 400000;
  localparam int CoordMax = (1 << CoordBits) - 1;

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     in_valid;
  logic     in_stall;
  dda_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  dda_out_t out_data;
  int       failures;
  int       pending;
  int       compared;
  int       items_sent = 0;
  int       loads_sent = 0;
  int       cycle_count = 0;
  bit       tx_gaps = 1'b0;
  bit       rx_stalls = 1'b0;
  bit       hold_req = 1'b0;

  always #5 clk_i = ~clk_i;

  dda_line_rasterizer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  pixel_checker pixel_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .failures_o  (failures),
    .pending_o   (pending),
    .compared_o  (compared)
  );

  function automatic dda_in_t random_item();
    logic [95:0] noise;
    noise = {$urandom(), $urandom(), $urandom()};
    return dda_in_t'(noise[$bits(dda_in_t)-1:0]);
  endfunction

  function automatic int pick_coord();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? CoordMax : 0;
    return $urandom_range(0, CoordMax);
  endfunction

  function automatic int line_length(input int sx, input int sy, input int ex, input int ey);
    int ax;
    int ay;
    ax = (ex > sx) ? ex - sx : sx - ex;
    ay = (ey > sy) ? ey - sy : sy - ey;
    return (ax > ay) ? ax : ay;
  endfunction

  task automatic send_item(input dda_in_t d);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= d;
    do @(posedge clk_i); while (in_stall);
  endtask

  // load a line, then ask for n_steps pixels; steps past the end draw nothing
  task automatic run_line(input int sx, input int sy, input int ex, input int ey,
                          input int n_steps);
    dda_in_t d;
    d = random_item();
    d.mode = MODE_LOAD;
    d.start_x = sx[CoordBits-1:0];
    d.start_y = sy[CoordBits-1:0];
    d.end_x = ex[CoordBits-1:0];
    d.end_y = ey[CoordBits-1:0];
    send_item(d);
    items_sent++;
    loads_sent++;
    for (int i = 0; i < n_steps; i++) begin
      d = random_item();
      d.mode = MODE_STEP;
      send_item(d);
      items_sent++;
    end
  endtask

  task automatic drain_pixels();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    out_stall <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        out_stall <= 1'b0;
      end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d pixels outstanding", cycle_count, pending);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    dda_in_t d;
    int sx;
    int sy;
    int ex;
    int ey;
    int len;
    int n;
    int kind;
    int next_phase;

    in_valid <= 1'b0;
    in_data <= '0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_gaps = 1'b1;
    rx_stalls = 1'b1;
    // step with no line loaded
    d = random_item();
    d.mode = MODE_STEP;
    send_item(d);
    items_sent++;
    run_line(5, 5, 5, 5, 1);
    run_line(0, 0, CoordMax, CoordMax, 3);
    run_line(CoordMax, CoordMax, 0, 0, 3);
    run_line(0, CoordMax, CoordMax, 0, 2);
    // exact halves round up, in both directions
    run_line(0, 0, 4, 1, 4);
    run_line(4, 1, 0, 0, 5);
    run_line(CoordMax, 0, CoordMax - 3, 0, 4);
    run_line(7, 3, 7, 0, 3);
    drain_pixels();

    // long receiver hold-off while the sender keeps stepping
    tx_gaps = 1'b0;
    hold_req = 1'b1;
    sx = $urandom_range(0, CoordMax - 300);
    sy = $urandom_range(0, CoordMax);
    run_line(sx, sy, sx + 300, $urandom_range(0, CoordMax), 301);
    drain_pixels();

    tx_gaps = 1'b1;
    next_phase = items_sent + 250;
    while (items_sent < ItemTarget) begin
      if (items_sent >= next_phase) begin
        drain_pixels();
        next_phase += 250;
        if (items_sent > ItemTarget - 300) begin
          tx_gaps = 1'b0;
          rx_stalls = 1'b0;
        end else begin
          tx_gaps = $urandom_range(0, 1);
          rx_stalls = $urandom_range(0, 1);
        end
      end
      kind = $urandom_range(0, 99);
      sx = pick_coord();
      sy = pick_coord();
      if (kind < 3) begin
        ex = pick_coord();
        ey = pick_coord();
      end else if (kind < 8) begin
        ex = sx;
        ey = sy;
      end else begin
        ex = sx + int'($urandom_range(0, 24)) - 12;
        ey = sy + int'($urandom_range(0, 24)) - 12;
        if (ex < 0) ex = 0;
        if (ex > CoordMax) ex = CoordMax;
        if (ey < 0) ey = 0;
        if (ey > CoordMax) ey = CoordMax;
      end
      len = line_length(sx, sy, ex, ey);
      if (kind < 3) n = ($urandom_range(0, 3) == 0) ? len + 1 : $urandom_range(1, 40);
      else if ($urandom_range(0, 5) == 0) n = $urandom_range(0, len);
      else n = len + $urandom_range(0, 2);
      // keep the item total close to the target
      if (n > ItemTarget + 19 - items_sent) n = ItemTarget + 19 - items_sent;
      run_line(sx, sy, ex, ey, n);
    end

    drain_pixels();
    repeat (20) @(posedge clk_i);
    $display("sent %0d items in %0d line loads, compared %0d pixels", items_sent,
             loads_sent, compared);
    $display("lines: zero-length, cut short, run past the end, full-range diagonals");
    if (failures == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
